### sv/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// shared types and constants of the chained hash table
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int BUCKETS_DEF = 256;
	localparam int NODES_DEF   = 256;
	localparam int CFG_W       = 9;
	localparam int BKT_MAX_W   = 16;
	localparam int DIV_STEPS   = 4;
	localparam int DIV_CYCLES  = 32 / DIV_STEPS;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_FIND   = 2'd2,
		MODE_BUCKET = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// one classified transaction on its way from front to back
	typedef struct packed {
		mode_t                 mode;
		logic [31:0]           key;
		logic [31:0]           value;
		logic [BKT_MAX_W-1:0]  bkt;
	} item_t;

endpackage

### sv/cht_front.sv
// ----------------------------------------------------------------------------
// cht_front
// accepts transactions and computes the bucket by iterative division
// ----------------------------------------------------------------------------
module cht_front #(
	parameter int BUCKETS = cht_pkg::BUCKETS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                mode,
	input  logic [31:0]               key,
	input  logic [31:0]               value,
	input  logic [cht_pkg::CFG_W-1:0] bucket_count,
	input  logic                      init_busy,
	output logic                      push,
	output cht_pkg::item_t            item,
	input  logic                      full
);
	import cht_pkg::*;

	localparam int DW = $clog2(BUCKETS + 1);
	localparam int CNW = $clog2(DIV_CYCLES);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

	fstate_t           state_q;
	logic [CNW-1:0]    cnt_q;
	logic [DW-1:0]     div_q;
	logic [DW-1:0]     rem_q;
	logic [31:0]       kshift_q;
	mode_t             mode_q;
	logic [31:0]       key_q;
	logic [31:0]       value_q;
	logic [DW-1:0]     eff;
	logic [DW-1:0]     rem_nxt;
	logic [31:0]       kshift_nxt;

	// register value of zero or above the table size means the full table
	always_comb begin
		if (bucket_count == '0 || 32'(bucket_count) > BUCKETS) begin
			eff = DW'(BUCKETS);
		end else begin
			eff = DW'(bucket_count);
		end
	end

	// restoring division, a few quotient bits per cycle
	always_comb begin
		logic [DW:0] t;
		rem_nxt    = rem_q;
		kshift_nxt = kshift_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {rem_nxt, kshift_nxt[31]};
			kshift_nxt = {kshift_nxt[30:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			rem_nxt = t[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid && !in_stall) begin
						mode_q   <= mode_t'(mode);
						key_q    <= key;
						value_q  <= value;
						kshift_q <= key;
						rem_q    <= '0;
						div_q    <= eff;
						cnt_q    <= '0;
						state_q  <= F_DIV;
					end
				end
				F_DIV: begin
					rem_q    <= rem_nxt;
					kshift_q <= kshift_nxt;
					cnt_q    <= cnt_q + CNW'(1);
					if (cnt_q == CNW'(DIV_CYCLES - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != F_IDLE) || init_busy;
	assign push       = (state_q == F_PUSH) && !full;
	assign item.mode  = mode_q;
	assign item.key   = key_q;
	assign item.value = value_q;
	assign item.bkt   = BKT_MAX_W'(rem_q);

endmodule

### sv/cht_queue.sv
// ----------------------------------------------------------------------------
// cht_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
module cht_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cht_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output cht_pkg::item_t q_item
);
	import cht_pkg::*;

	item_t       slots [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = slots[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### sv/cht_back.sv
// ----------------------------------------------------------------------------
// cht_back
// executes table operations against bucket heads, node store and free list
// ----------------------------------------------------------------------------
module cht_back #(
	parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
	parameter int NODES   = cht_pkg::NODES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  cht_pkg::item_t q_item,
	output logic           q_pop,
	output logic           init_busy,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     status,
	output logic [31:0]    found_value,
	output logic [7:0]     bucket,
	output logic [8:0]     entry_count
);
	import cht_pkg::*;

	localparam int BKW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NIW  = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LW   = $clog2(NODES + 1);
	localparam int CW   = $clog2(NODES + 1);
	localparam int MAXD = (BUCKETS > NODES) ? BUCKETS : NODES;
	localparam int IW   = $clog2(MAXD + 1);

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_HEAD, S_INS2, S_WALK, S_CMP, S_RES
	} bstate_t;

	// storage
	logic [LW-1:0]  heads     [BUCKETS];
	logic [NIW-1:0] free_list [NODES];
	logic [31:0]    node_keys [NODES];
	logic [31:0]    node_vals [NODES];
	logic [LW-1:0]  node_next [NODES];
	logic [LW-1:0]  node_prev [NODES];

	bstate_t        state_q;
	logic [IW-1:0]  ini_q;
	logic [CW-1:0]  cnt_q;
	logic [LW-1:0]  link_q;
	logic [NIW-1:0] node_q;
	mode_t          mode_q;
	logic [31:0]    key_q;
	logic [31:0]    value_q;
	logic [BKW-1:0] bkt_q;
	status_t        res_st_q;
	logic [31:0]    res_fv_q;
	logic           out_valid_q;
	status_t        out_st_q;
	logic [31:0]    out_fv_q;
	logic [7:0]     out_bkt_q;
	logic [8:0]     out_cnt_q;
	logic           res_load;

	// registered read data
	logic [LW-1:0]  hd_rd_q;
	logic [NIW-1:0] fl_rd_q;
	logic [31:0]    key_rd_q;
	logic [31:0]    val_rd_q;
	logic [LW-1:0]  nx_rd_q;
	logic [LW-1:0]  pv_rd_q;

	// write ports
	logic           hd_we;
	logic [BKW-1:0] hd_wa;
	logic [LW-1:0]  hd_wd;
	logic           fl_we;
	logic [NIW-1:0] fl_wa;
	logic [NIW-1:0] fl_wd;
	logic           nk_we;
	logic [NIW-1:0] nk_wa;
	logic           nx_we;
	logic [NIW-1:0] nx_wa;
	logic [LW-1:0]  nx_wd;
	logic           pv_we;
	logic [NIW-1:0] pv_wa;
	logic [LW-1:0]  pv_wd;

	// read addresses
	logic [BKW-1:0] hd_ra;
	logic [NIW-1:0] fl_ra;
	logic [NIW-1:0] nd_ra;
	logic           key_hit;

	assign hd_ra   = q_item.bkt[BKW-1:0];
	assign fl_ra   = NIW'(CW'(NODES - 1) - cnt_q);
	assign nd_ra   = NIW'(link_q - LW'(1));
	assign key_hit = (key_rd_q == key_q);

	// result register takes a new transaction when empty or being drained
	assign res_load = (state_q == S_RES) && (!out_valid_q || !out_stall);

	always_comb begin
		hd_we = 1'b0;
		hd_wa = bkt_q;
		hd_wd = '0;
		fl_we = 1'b0;
		fl_wa = NIW'(CW'(NODES) - cnt_q);
		fl_wd = nd_ra;
		nk_we = 1'b0;
		nk_wa = fl_rd_q;
		nx_we = 1'b0;
		nx_wa = fl_rd_q;
		nx_wd = hd_rd_q;
		pv_we = 1'b0;
		pv_wa = fl_rd_q;
		pv_wd = '0;
		unique case (state_q)
			S_INIT: begin
				hd_we = (ini_q < IW'(BUCKETS));
				hd_wa = BKW'(ini_q);
				fl_we = (ini_q < IW'(NODES));
				fl_wa = NIW'(ini_q);
				fl_wd = NIW'(ini_q);
			end
			S_HEAD: begin
				if (mode_q == MODE_INSERT) begin
					hd_we = 1'b1;
					hd_wd = LW'(fl_rd_q) + LW'(1);
					nk_we = 1'b1;
					nx_we = 1'b1;
					pv_we = 1'b1;
				end
			end
			S_INS2: begin
				pv_we = 1'b1;
				pv_wa = nd_ra;
				pv_wd = LW'(node_q) + LW'(1);
			end
			S_CMP: begin
				if (key_hit && mode_q == MODE_DELETE) begin
					if (pv_rd_q == '0) begin
						hd_we = 1'b1;
						hd_wd = nx_rd_q;
					end else begin
						nx_we = 1'b1;
						nx_wa = NIW'(pv_rd_q - LW'(1));
						nx_wd = nx_rd_q;
					end
					if (nx_rd_q != '0) begin
						pv_we = 1'b1;
						pv_wa = NIW'(nx_rd_q - LW'(1));
						pv_wd = pv_rd_q;
					end
					fl_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (hd_we) begin
			heads[hd_wa] <= hd_wd;
		end
		hd_rd_q <= heads[hd_ra];
	end

	always_ff @(posedge clk) begin
		if (fl_we) begin
			free_list[fl_wa] <= fl_wd;
		end
		fl_rd_q <= free_list[fl_ra];
	end

	always_ff @(posedge clk) begin
		if (nk_we) begin
			node_keys[nk_wa] <= key_q;
			node_vals[nk_wa] <= value_q;
		end
		key_rd_q <= node_keys[nd_ra];
		val_rd_q <= node_vals[nd_ra];
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			node_next[nx_wa] <= nx_wd;
		end
		nx_rd_q <= node_next[nd_ra];
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			node_prev[pv_wa] <= pv_wd;
		end
		pv_rd_q <= node_prev[nd_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			ini_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					ini_q <= ini_q + IW'(1);
					if (ini_q == IW'(MAXD - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						mode_q   <= q_item.mode;
						key_q    <= q_item.key;
						value_q  <= q_item.value;
						bkt_q    <= q_item.bkt[BKW-1:0];
						res_st_q <= ST_OK;
						res_fv_q <= '0;
						unique case (q_item.mode)
							MODE_BUCKET: begin
								state_q <= S_RES;
							end
							MODE_INSERT: begin
								if (cnt_q == CW'(NODES)) begin
									res_st_q <= ST_FULL;
									state_q  <= S_RES;
								end else begin
									state_q <= S_HEAD;
								end
							end
							default: begin
								state_q <= S_HEAD;
							end
						endcase
					end
				end
				S_HEAD: begin
					link_q <= hd_rd_q;
					if (mode_q == MODE_INSERT) begin
						cnt_q  <= cnt_q + CW'(1);
						node_q <= fl_rd_q;
						state_q <= (hd_rd_q != '0) ? S_INS2 : S_RES;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_INS2: begin
					state_q <= S_RES;
				end
				S_WALK: begin
					if (link_q == '0) begin
						res_st_q <= ST_MISS;
						state_q  <= S_RES;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (key_hit) begin
						if (mode_q == MODE_FIND) begin
							res_fv_q <= val_rd_q;
							res_st_q <= (val_rd_q == '0) ? ST_MISS : ST_OK;
						end else begin
							cnt_q <= cnt_q - CW'(1);
						end
						state_q <= S_RES;
					end else begin
						link_q  <= nx_rd_q;
						state_q <= S_WALK;
					end
				end
				S_RES: begin
					if (res_load) begin
						out_st_q    <= res_st_q;
						out_fv_q    <= res_fv_q;
						out_bkt_q   <= 8'(bkt_q);
						out_cnt_q   <= 9'(cnt_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign q_pop       = (state_q == S_IDLE) && q_valid;
	assign init_busy   = (state_q == S_INIT);
	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign found_value = out_fv_q;
	assign bucket      = out_bkt_q;
	assign entry_count = out_cnt_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NODES))
		else $error("entry count beyond node pool");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HEAD && mode_q == MODE_INSERT) |-> cnt_q < CW'(NODES))
		else $error("insert reached allocation with pool exhausted");
	a_res_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RES && !(out_valid_q && out_stall)) |=> out_valid_q)
		else $error("finished result not presented");
`endif

endmodule

### sv/chained_hash_table_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_unit
// key-to-value table with separately chained buckets and a fixed node pool
// ----------------------------------------------------------------------------
// after reset the unit runs a clearing pass that empties every bucket head and
// fills the free list; no transaction is taken meanwhile, though bucket_count
// writes are. a transaction then goes through a front that finds its bucket as
// key modulo bucket_count with a restoring divider of four bits per cycle and
// takes no new one until it has pushed the last, a two-entry queue, and a
// back that works on bucket heads, node store and free list, each a memory
// with one write and one registered read port. in the back, bucket-only and
// pool-full inserts go from idle straight to the result; other inserts write
// the head and, if the chain was not empty, the old head's back link; find or
// delete read the head, then take a registered read and a compare per chain
// node visited, plus one read step when the key is not in the chain. results
// wait in an output register so the back can run while the consumer stalls.
// ----------------------------------------------------------------------------
module chained_hash_table_unit #(
	parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
	parameter int NODES   = cht_pkg::NODES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [cht_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                mode,
	input  logic [31:0]               key,
	input  logic [31:0]               value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [31:0]               found_value,
	output logic [7:0]                bucket,
	output logic [8:0]                entry_count
);
	import cht_pkg::*;

	logic [CFG_W-1:0] bucket_count_q;
	logic             init_busy;
	logic             push;
	item_t            push_item;
	logic             full;
	logic             pop;
	logic             q_valid;
	item_t            q_item;

	// bucket count register, reset to the full table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CFG_W'(BUCKETS);
		end else if (cfg_wr_en) begin
			bucket_count_q <= cfg_wr_data;
		end
	end

	// front: take the transaction and compute its bucket
	cht_front #(
		.BUCKETS(BUCKETS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.key          (key),
		.value        (value),
		.bucket_count (bucket_count_q),
		.init_busy    (init_busy),
		.push         (push),
		.item         (push_item),
		.full         (full)
	);

	// decouples divider latency from chain walking
	cht_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// back: chain walk, link update and result register
	cht_back #(
		.BUCKETS(BUCKETS),
		.NODES  (NODES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (pop),
		.init_busy   (init_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found_value (found_value),
		.bucket      (bucket),
		.entry_count (entry_count)
	);

endmodule
